FILE: design/wft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wft_pkg;

   localparam int LETTER_BITS = 5;
   localparam int WORD_BITS   = 60;
   localparam int LEN_BITS    = 4;
   localparam int COUNT_BITS  = 32;
   localparam int ENTRY_BITS  = WORD_BITS + LEN_BITS + COUNT_BITS;

   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_NONE      = 3'd0,
      ST_ADDED     = 3'd1,
      ST_COUNTED   = 3'd2,
      ST_NONLETTER = 3'd3,
      ST_TOOLONG   = 3'd4,
      ST_FULL      = 3'd5,
      ST_READ      = 3'd6,
      ST_BADINDEX  = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_READWAIT,
      S_READOUT,
      S_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take_byte;
      logic drop_token;
      logic start_scan;
      logic scan_next;
      logic do_check;
      logic do_hit;
      logic do_append;
      logic do_full;
      logic do_read;
      logic do_read_data;
      logic do_simple;
      logic out_load;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic is_space;
      logic token_empty;
      logic token_bad;
      logic scan_done;
      logic scan_match;
      logic scan_hit;
      logic table_full;
      logic index_ok;
      logic out_busy;
   } stat_type;

endpackage
`default_nettype wire

FILE: design/wft_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module wft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/wft_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module wft_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_cmd,
   input  wire wft_pkg::stat_type    stat,
   output wft_pkg::ctrl_type         ctrl
);
   wft_pkg::state_type state_ff, state_in;
   wft_pkg::cmd_type   cmd;
   logic               accept;

   assign cmd       = wft_pkg::cmd_type'(req_cmd);
   assign req_stall = (state_ff != wft_pkg::S_IDLE) || stat.out_busy;
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wft_pkg::S_IDLE: begin
            if (accept) begin
               case (cmd)
                  wft_pkg::CMD_READ: begin
                     if (stat.index_ok) state_in = wft_pkg::S_READWAIT;
                  end
                  wft_pkg::CMD_BYTE, wft_pkg::CMD_FLUSH: begin
                     if ((cmd == wft_pkg::CMD_FLUSH || stat.is_space) &&
                         !stat.token_empty && !stat.token_bad)
                        state_in = wft_pkg::S_SCAN;
                  end
                  default: state_in = wft_pkg::S_IDLE;
               endcase
            end
         end
         wft_pkg::S_SCAN:     if (stat.scan_done) state_in = wft_pkg::S_OUT;
                              else state_in = wft_pkg::S_CHECK;
         wft_pkg::S_CHECK: begin
            if (stat.scan_match) state_in = wft_pkg::S_OUT;
            else state_in = wft_pkg::S_SCAN;
         end
         wft_pkg::S_READWAIT: state_in = wft_pkg::S_READOUT;
         wft_pkg::S_READOUT:  state_in = wft_pkg::S_IDLE;
         wft_pkg::S_OUT:      state_in = wft_pkg::S_IDLE;
         default:             state_in = wft_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         wft_pkg::S_IDLE: begin
            if (accept) begin
               case (cmd)
                  wft_pkg::CMD_READ: begin
                     ctrl.do_read = 1'b1;
                     if (!stat.index_ok) ctrl.do_simple = 1'b1;
                  end
                  wft_pkg::CMD_BYTE, wft_pkg::CMD_FLUSH: begin
                     if (cmd == wft_pkg::CMD_BYTE && !stat.is_space) begin
                        ctrl.take_byte = 1'b1;
                        ctrl.do_simple = 1'b1;
                     end else if (stat.token_empty || stat.token_bad) begin
                        ctrl.drop_token = 1'b1;
                        ctrl.do_simple  = 1'b1;
                     end else begin
                        ctrl.start_scan = 1'b1;
                     end
                  end
                  default: ctrl.do_simple = 1'b1;
               endcase
            end
         end
         wft_pkg::S_SCAN: ctrl.scan_next = !stat.scan_done;
         wft_pkg::S_CHECK: ctrl.do_check = 1'b1;
         wft_pkg::S_READOUT: ctrl.do_read_data = 1'b1;
         wft_pkg::S_OUT: begin
            if (stat.scan_hit)        ctrl.do_hit = 1'b1;
            else if (stat.table_full) ctrl.do_full = 1'b1;
            else                      ctrl.do_append = 1'b1;
         end
         default: ctrl = '0;
      endcase
      ctrl.out_load = ctrl.do_simple || ctrl.do_hit || ctrl.do_full ||
                      ctrl.do_append || ctrl.do_read_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wft_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // no item taken while busy
   ap_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != wft_pkg::S_IDLE) |-> req_stall)
      else $error("item accepted while busy");
   // a read always ends with a result
   ap_read_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wft_pkg::S_READWAIT) |=> ctrl.do_read_data)
      else $error("read lost");
   // one result source at a time
   ap_one_src: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.do_simple, ctrl.do_hit, ctrl.do_full, ctrl.do_append,
                ctrl.do_read_data}))
      else $error("result sources collide");
endmodule
`default_nettype wire

FILE: design/wft_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module wft_datapath #(
   parameter int TABLE_DEPTH = 256,
   parameter int MAX_LETTERS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [7:0]           req_text_byte,
   input  wire logic [7:0]           req_entry_index,
   input  wire logic                 rsp_stall,
   input  wire wft_pkg::ctrl_type    ctrl,
   output wft_pkg::stat_type         stat,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic [59:0]               rsp_word_letters,
   output logic [3:0]                rsp_word_length,
   output logic [31:0]               rsp_word_count,
   output logic [8:0]                rsp_table_entries,
   output logic [7:0]                rsp_hit_position
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW = $clog2(TABLE_DEPTH + 1);
   localparam int EB = wft_pkg::ENTRY_BITS;

   // token state
   logic [59:0]   tok_ff;
   logic [3:0]    tlen_ff;
   logic          tbad_ff, tlong_ff;
   logic [NW-1:0] total_ff;
   logic [NW-1:0] scan_ff;
   logic [AW-1:0] ram_addr, wr_addr;
   logic          wr_en;
   logic [EB-1:0] wr_data, rd_data;
   logic [59:0]   rd_word;
   logic [3:0]    rd_len;
   logic [31:0]   rd_cnt, inc_cnt;
   logic          hit_ff;
   logic [AW-1:0] hit_addr_ff;
   logic [31:0]   hit_cnt_ff;
   logic          match;
   logic [4:0]    code;
   logic          sp;

   assign sp = (req_text_byte == 8'h20) ||
               (req_text_byte >= 8'h09 && req_text_byte <= 8'h0D);
   always_comb begin
      code = 5'd0;
      if (req_text_byte >= 8'h41 && req_text_byte <= 8'h5A)
         code = 5'(req_text_byte - 8'h40);
      else if (req_text_byte >= 8'h61 && req_text_byte <= 8'h7A)
         code = 5'(req_text_byte - 8'h60);
   end

   assign {rd_word, rd_len, rd_cnt} = rd_data;
   assign match   = (rd_len == tlen_ff) && (rd_word == tok_ff);
   assign inc_cnt = (hit_cnt_ff == 32'hFFFF_FFFF) ? hit_cnt_ff : hit_cnt_ff + 32'd1;

   assign stat.is_space    = sp;
   assign stat.token_empty = (tlen_ff == 4'd0) && !tbad_ff && !tlong_ff;
   assign stat.token_bad   = tbad_ff || tlong_ff;
   assign stat.scan_done   = (scan_ff >= total_ff);
   assign stat.scan_match  = match;
   assign stat.scan_hit    = hit_ff;
   assign stat.table_full  = (total_ff >= NW'(TABLE_DEPTH));
   assign stat.index_ok    = ({1'b0, req_entry_index} < 9'(total_ff)) &&
                             (32'(req_entry_index) < TABLE_DEPTH);
   assign stat.out_busy    = rsp_valid && rsp_stall;

   // ram address: read index, scan pointer, or write target
   always_comb begin
      if (ctrl.do_read) ram_addr = AW'(req_entry_index);
      else              ram_addr = AW'(scan_ff);
      wr_en   = ctrl.do_hit || ctrl.do_append;
      wr_addr = ctrl.do_hit ? hit_addr_ff : AW'(total_ff);
      wr_data = ctrl.do_hit ? {tok_ff, tlen_ff, inc_cnt}
                            : {tok_ff, tlen_ff, 32'd1};
   end

   wft_ram #(.WIDTH(EB), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(ram_addr),
      .rd_data(rd_data)
   );

   // token assembly, scan pointer and table count
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         tlen_ff  <= '0;
         tbad_ff  <= 1'b0;
         tlong_ff <= 1'b0;
         total_ff <= '0;
         scan_ff  <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (ctrl.take_byte) begin
            if (code == 5'd0) begin
               tbad_ff <= 1'b1;
            end else if (32'(tlen_ff) < MAX_LETTERS) begin
               tok_ff[5*tlen_ff +: 5] <= code;
               tlen_ff <= tlen_ff + 4'd1;
            end else begin
               tlong_ff <= 1'b1;
            end
         end
         // empty or faulty token end: drop it
         if (ctrl.drop_token) begin
            tok_ff   <= '0;
            tlen_ff  <= '0;
            tbad_ff  <= 1'b0;
            tlong_ff <= 1'b0;
         end
         if (ctrl.start_scan) begin
            scan_ff <= '0;
            hit_ff  <= 1'b0;
         end
         if (ctrl.scan_next) scan_ff <= scan_ff + NW'(1);
         // read address kept for reporting
         if (ctrl.do_read && !ctrl.do_simple) scan_ff <= NW'(req_entry_index);
         // compare the registered ram word with the token, in the cycle after its address is set
         if (ctrl.do_check && match) hit_ff <= 1'b1;
         if (ctrl.do_append) total_ff <= total_ff + NW'(1);
         if (ctrl.do_hit || ctrl.do_append || ctrl.do_full) begin
            tok_ff   <= '0;
            tlen_ff  <= '0;
            hit_ff   <= 1'b0;
         end
      end
   end

   // address and count of the entry under compare
   always_ff @(posedge clock) begin
      if (ctrl.scan_next) hit_addr_ff <= AW'(scan_ff);
      if (ctrl.do_check && match) hit_cnt_ff <= rd_cnt;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_word_letters  <= '0;
         rsp_word_length   <= '0;
         rsp_word_count    <= '0;
         rsp_hit_position  <= '0;
         rsp_table_entries <= 9'(total_ff);
         rsp_status        <= wft_pkg::ST_NONE;
         if (ctrl.do_simple) begin
            if (ctrl.do_read) rsp_status <= wft_pkg::ST_BADINDEX;
            else if (ctrl.drop_token && tbad_ff) rsp_status <= wft_pkg::ST_NONLETTER;
            else if (ctrl.drop_token && tlong_ff) rsp_status <= wft_pkg::ST_TOOLONG;
         end else if (ctrl.do_read_data) begin
            rsp_status       <= wft_pkg::ST_READ;
            rsp_word_letters <= rd_word;
            rsp_word_length  <= rd_len;
            rsp_word_count   <= rd_cnt;
            rsp_hit_position <= 8'(scan_ff);
         end else if (ctrl.do_hit) begin
            rsp_status       <= wft_pkg::ST_COUNTED;
            rsp_word_letters <= tok_ff;
            rsp_word_length  <= tlen_ff;
            rsp_word_count   <= inc_cnt;
            rsp_hit_position <= 8'(hit_addr_ff);
         end else if (ctrl.do_full) begin
            rsp_status       <= wft_pkg::ST_FULL;
            rsp_word_letters <= tok_ff;
            rsp_word_length  <= tlen_ff;
         end else begin
            rsp_status        <= wft_pkg::ST_ADDED;
            rsp_word_letters  <= tok_ff;
            rsp_word_length   <= tlen_ff;
            rsp_word_count    <= 32'd1;
            rsp_hit_position  <= 8'(total_ff);
            rsp_table_entries <= 9'(total_ff + NW'(1));
         end
      end
   end

   // a result is not overwritten while stalled
   ap_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !ctrl.out_load)
      else $error("result overwritten");
   // table never grows beyond its depth
   ap_total: assert property (@(posedge clock) disable iff (reset)
      total_ff <= NW'(TABLE_DEPTH))
      else $error("table overflow");
   // token length bound
   ap_len: assert property (@(posedge clock) disable iff (reset)
      32'(tlen_ff) <= MAX_LETTERS)
      else $error("token too long");

   logic unused;
   assign unused = ^{req_cmd};
endmodule
`default_nettype wire

FILE: design/word_frequency_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// text byte, bad read, empty or dropped token end: result in the cycle after acceptance
// read of a stored entry: states S_READWAIT, S_READOUT; token end: S_SCAN and S_CHECK in turn for each
// stored word until a match or the end of the table, then S_OUT
// one result per item; the scan uses the single ram port; no item is taken while busy or stalled
// reset: synchronous, clears the token, the word count and the handshake state
// ram contents are left undefined by reset; entries are read only once written
module word_frequency_table_unit #(
   parameter int TABLE_DEPTH = 256,
   parameter int MAX_LETTERS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic [7:0]  req_entry_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [59:0]      rsp_word_letters,
   output logic [3:0]       rsp_word_length,
   output logic [31:0]      rsp_word_count,
   output logic [8:0]       rsp_table_entries,
   output logic [7:0]       rsp_hit_position
);
   wft_pkg::ctrl_type ctrl;
   wft_pkg::stat_type stat;

   wft_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd  (req_cmd),
      .stat     (stat),
      .ctrl     (ctrl)
   );

   wft_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_LETTERS(MAX_LETTERS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_text_byte    (req_text_byte),
      .req_entry_index  (req_entry_index),
      .rsp_stall        (rsp_stall),
      .ctrl             (ctrl),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_word_letters (rsp_word_letters),
      .rsp_word_length  (rsp_word_length),
      .rsp_word_count   (rsp_word_count),
      .rsp_table_entries(rsp_table_entries),
      .rsp_hit_position (rsp_hit_position)
   );
endmodule
`default_nettype wire
